// ===== rtl/mec_pkg.sv =====
// shared types, widths and constants for the mandelbrot escape count core
`timescale 1ns / 1ps

package mec_pkg;

   // field and format widths
   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 28;
   localparam int ITER_BITS  = 24;
   localparam int STEP_BITS  = 31;
   localparam int ORIGIN_BITS = 32;

   // inner fixed-point format: 8 integer bits plus the fraction
   localparam int INNER_W = FRAC_BITS + 8;
   localparam int MAG_W   = INNER_W;
   localparam int LO_W    = (MAG_W + 1) / 2;
   localparam int HI_W    = MAG_W - LO_W;
   localparam int LO_PROD_W = MAG_W + LO_W;
   localparam int HI_PROD_W = MAG_W + HI_W;
   localparam int PROD_W  = 2 * MAG_W;

   // pixel offset product and the working width for saturating sums
   localparam int OFFSET_W = STEP_BITS + COORD_BITS;
   localparam int WIDE_W   = (OFFSET_W + 2 > INNER_W + 2) ? OFFSET_W + 2 : INNER_W + 2;

   // stream widths, rounded up to whole bytes
   localparam int REQ_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((ITER_BITS + 7) / 8) * 8;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_REAL = 2'd0,
      CSR_START_IMAG = 2'd1,
      CSR_PIXEL_STEP = 2'd2,
      CSR_MAX_ITERS  = 2'd3
   } csr_index_type;

   // reset values of the configuration registers
   localparam logic signed [ORIGIN_BITS-1:0] START_REAL_RST = 32'hE000_0000;
   localparam logic signed [ORIGIN_BITS-1:0] START_IMAG_RST = 32'h1000_0000;
   localparam logic [STEP_BITS-1:0]          PIXEL_STEP_RST = 31'd262144;
   localparam logic [ITER_BITS-1:0]          MAX_ITERS_RST  = ITER_BITS'(1000);

   typedef logic signed [INNER_W-1:0] inner_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;
   typedef logic [MAG_W-1:0]          mag_type;
   typedef logic [PROD_W-1:0]         prod_type;

   // escape threshold 4.0 in the inner format
   localparam inner_type INNER_FOUR = INNER_W'(1) << (FRAC_BITS + 2);

   typedef struct packed {
      logic signed [ORIGIN_BITS-1:0] start_real;
      logic signed [ORIGIN_BITS-1:0] start_imag;
      logic [STEP_BITS-1:0]          pixel_step;
      logic [ITER_BITS-1:0]          max_iters;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_ORIGIN,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_PROD,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic scale;
      logic origin;
      logic mul_lo;
      logic mul_hi;
      logic prod;
      logic update;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic iterate;
   } status_type;

endpackage

// ===== rtl/mandelbrot_escape_count_core.sv =====
// top level of the mandelbrot escape count core
//
//   channel   direction  handshake                  payload
//   req       in         req_tvalid / req_tready    tdata: row, col
//   rsp       out        rsp_tvalid / rsp_tready    tdata: iteration_count
//   csr       in         csr_valid / csr_ready      csr_index, csr_wdata
//
// each iteration makes two passes through three shared operand-by-half-width
// multipliers, then joins and saturates the products and then updates z, s
// and the count.
// one item is in work at a time; the next one is accepted while a result
// still waits in the output register.
// reset is synchronous and loads the default view and a limit of 1000.
`timescale 1ns / 1ps

module mandelbrot_escape_count_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [11:0] row, [23:12] col
   input  logic [mec_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [23:0] iteration_count
   output logic [mec_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mec_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mec_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   mec_pkg::cfg_type                cfg;
   mec_pkg::cmd_type                cmd;
   mec_pkg::status_type             status;
   logic [mec_pkg::ITER_BITS-1:0]   result_count;

   // configuration registers
   mec_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer
   mec_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // arithmetic
   mec_datapath u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .cfg          (cfg),
      .req_tdata    (req_tdata),
      .status       (status),
      .result_count (result_count)
   );

   assign rsp_tdata = mec_pkg::RSP_DATA_W'(result_count);

endmodule

// ===== rtl/mec_csr.sv =====
// configuration registers: start point, pixel step and iteration limit
`timescale 1ns / 1ps

module mec_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mec_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mec_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output mec_pkg::cfg_type                  cfg
);

   mec_pkg::cfg_type cfg_ff;
   mec_pkg::cfg_type cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;

   // decode the register index, upper data bits are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (mec_pkg::csr_index_type'(csr_index))
            mec_pkg::CSR_START_REAL: begin
               cfg_in.start_real = csr_wdata[mec_pkg::ORIGIN_BITS-1:0];
            end
            mec_pkg::CSR_START_IMAG: begin
               cfg_in.start_imag = csr_wdata[mec_pkg::ORIGIN_BITS-1:0];
            end
            mec_pkg::CSR_PIXEL_STEP: begin
               cfg_in.pixel_step = csr_wdata[mec_pkg::STEP_BITS-1:0];
            end
            mec_pkg::CSR_MAX_ITERS: begin
               cfg_in.max_iters = csr_wdata[mec_pkg::ITER_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_real <= mec_pkg::START_REAL_RST;
         cfg_ff.start_imag <= mec_pkg::START_IMAG_RST;
         cfg_ff.pixel_step <= mec_pkg::PIXEL_STEP_RST;
         cfg_ff.max_iters  <= mec_pkg::MAX_ITERS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/mec_ctrl.sv =====
// sequencer for one pixel: setup, four-step iteration loop, result handoff
`timescale 1ns / 1ps

module mec_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  mec_pkg::status_type  status,
   output mec_pkg::cmd_type     cmd
);

   mec_pkg::state_type state_ff;
   mec_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   // next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         mec_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = mec_pkg::ST_SCALE;
            end
         end
         mec_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = mec_pkg::ST_ORIGIN;
         end
         mec_pkg::ST_ORIGIN: begin
            cmd.origin = 1'b1;
            state_in   = mec_pkg::ST_MUL_LO;
         end
         mec_pkg::ST_MUL_LO: begin
            // loop test sits on the first multiply step
            if (status.iterate) begin
               cmd.mul_lo = 1'b1;
               state_in   = mec_pkg::ST_MUL_HI;
            end else begin
               state_in   = mec_pkg::ST_DONE;
            end
         end
         mec_pkg::ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = mec_pkg::ST_PROD;
         end
         mec_pkg::ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = mec_pkg::ST_UPDATE;
         end
         mec_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = mec_pkg::ST_MUL_LO;
         end
         mec_pkg::ST_DONE: begin
            // hand the count to the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_result = 1'b1;
               state_in        = mec_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mec_pkg::ST_IDLE;
         end
      endcase
   end

   // output register valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mec_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/mec_datapath.sv =====
// point forming, split multipliers, saturating z update and count
`timescale 1ns / 1ps

module mec_datapath (
   input  logic                                clock,
   input  mec_pkg::cmd_type                    cmd,
   input  mec_pkg::cfg_type                    cfg,
   input  logic [mec_pkg::REQ_DATA_W-1:0]      req_tdata,
   output mec_pkg::status_type                 status,
   output logic [mec_pkg::ITER_BITS-1:0]       result_count
);

   localparam int COORD_BITS = mec_pkg::COORD_BITS;
   localparam int INNER_W    = mec_pkg::INNER_W;
   localparam int WIDE_W     = mec_pkg::WIDE_W;
   localparam int MAG_W      = mec_pkg::MAG_W;
   localparam int LO_W       = mec_pkg::LO_W;
   localparam int PROD_W     = mec_pkg::PROD_W;
   localparam int FRAC_BITS  = mec_pkg::FRAC_BITS;
   localparam int ITER_BITS  = mec_pkg::ITER_BITS;
   localparam int NPROD      = 3;

   // clamp a wide signed value into the inner range
   function automatic mec_pkg::inner_type sat_inner(input mec_pkg::wide_type x);
      logic [WIDE_W-INNER_W:0] upper;
      upper = x[WIDE_W-1:INNER_W-1];
      if (&upper || ~|upper) begin
         return x[INNER_W-1:0];
      end else if (x[WIDE_W-1]) begin
         return {1'b1, {(INNER_W-1){1'b0}}};
      end else begin
         return {1'b0, {(INNER_W-1){1'b1}}};
      end
   endfunction

   // magnitude of an inner value, the most negative one included
   function automatic mec_pkg::mag_type mag_of(input mec_pkg::inner_type v);
      mec_pkg::inner_type negv;
      negv = -v;
      return v[INNER_W-1] ? mec_pkg::mag_type'(negv) : mec_pkg::mag_type'(v);
   endfunction

   // limit a shifted product magnitude, then apply the sign
   function automatic mec_pkg::inner_type sat_mag(input mec_pkg::prod_type q,
                                                  input logic neg);
      mec_pkg::mag_type lim;
      mec_pkg::mag_type mag;
      lim = neg ? {1'b1, {(MAG_W-1){1'b0}}} : {1'b0, {(MAG_W-1){1'b1}}};
      if (|q[PROD_W-1:MAG_W] || (q[MAG_W-1:0] > lim)) begin
         mag = lim;
      end else begin
         mag = q[MAG_W-1:0];
      end
      return neg ? -mec_pkg::inner_type'(mag) : mec_pkg::inner_type'(mag);
   endfunction

   logic [COORD_BITS-1:0]         row_ff;
   logic [COORD_BITS-1:0]         col_ff;
   logic [mec_pkg::OFFSET_W-1:0]  step_row_ff;
   logic [mec_pkg::OFFSET_W-1:0]  step_col_ff;
   mec_pkg::inner_type            cr_ff;
   mec_pkg::inner_type            ci_ff;
   mec_pkg::inner_type            zr_ff;
   mec_pkg::inner_type            zi_ff;
   mec_pkg::inner_type            s_ff;
   logic [ITER_BITS-1:0]          count_ff;
   mec_pkg::inner_type            rr_ff;
   mec_pkg::inner_type            ii_ff;
   mec_pkg::inner_type            cross_ff;
   logic [mec_pkg::LO_PROD_W-1:0] lo_ff [NPROD];
   logic [mec_pkg::HI_PROD_W-1:0] hi_ff [NPROD];
   logic [ITER_BITS-1:0]          result_ff;

   mec_pkg::mag_type   op_a [NPROD];
   mec_pkg::mag_type   op_b [NPROD];
   mec_pkg::prod_type  full [NPROD];
   mec_pkg::mag_type   mag_zr;
   mec_pkg::mag_type   mag_zi;
   mec_pkg::inner_type cr_in;
   mec_pkg::inner_type ci_in;
   mec_pkg::inner_type s_in;
   mec_pkg::inner_type zr_in;
   mec_pkg::inner_type zi_in;
   mec_pkg::inner_type diff;
   logic               cross_neg;

   // capture the pixel coordinates
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff <= req_tdata[COORD_BITS-1:0];
         col_ff <= req_tdata[2*COORD_BITS-1:COORD_BITS];
      end
   end

   // pixel offsets from the step size
   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         step_row_ff <= mec_pkg::OFFSET_W'(cfg.pixel_step) * mec_pkg::OFFSET_W'(row_ff);
         step_col_ff <= mec_pkg::OFFSET_W'(cfg.pixel_step) * mec_pkg::OFFSET_W'(col_ff);
      end
   end

   // point c, saturated into the inner range
   always_comb begin
      cr_in = sat_inner(mec_pkg::wide_type'($signed(cfg.start_real))
                        + mec_pkg::wide_type'({1'b0, step_col_ff}));
      ci_in = sat_inner(mec_pkg::wide_type'($signed(cfg.start_imag))
                        - mec_pkg::wide_type'({1'b0, step_row_ff}));
   end

   // multiplier operands: zr*zr, zi*zi and zr*zi on magnitudes
   always_comb begin
      mag_zr    = mag_of(zr_ff);
      mag_zi    = mag_of(zi_ff);
      op_a[0]   = mag_zr;
      op_b[0]   = mag_zr;
      op_a[1]   = mag_zi;
      op_b[1]   = mag_zi;
      op_a[2]   = mag_zr;
      op_b[2]   = mag_zi;
      cross_neg = zr_ff[INNER_W-1] ^ zi_ff[INNER_W-1];
   end

   // low and high halves of the second operand in two passes
   always_ff @(posedge clock) begin
      for (int k = 0; k < NPROD; k++) begin
         if (cmd.mul_lo) begin
            lo_ff[k] <= mec_pkg::LO_PROD_W'(op_a[k])
                        * mec_pkg::LO_PROD_W'(op_b[k][LO_W-1:0]);
         end
         if (cmd.mul_hi) begin
            hi_ff[k] <= mec_pkg::HI_PROD_W'(op_a[k])
                        * mec_pkg::HI_PROD_W'(op_b[k][MAG_W-1:LO_W]);
         end
      end
   end

   // join the halves, drop the fraction and saturate
   always_comb begin
      for (int k = 0; k < NPROD; k++) begin
         full[k] = (PROD_W'(hi_ff[k]) << LO_W) + PROD_W'(lo_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prod) begin
         rr_ff    <= sat_mag(full[0] >> FRAC_BITS, 1'b0);
         ii_ff    <= sat_mag(full[1] >> FRAC_BITS, 1'b0);
         cross_ff <= sat_mag(full[2] >> (FRAC_BITS - 1), cross_neg);
      end
   end

   // squared magnitude and next z from the products
   always_comb begin
      s_in  = sat_inner(mec_pkg::wide_type'(rr_ff) + mec_pkg::wide_type'(ii_ff));
      zi_in = sat_inner(mec_pkg::wide_type'(cross_ff) + mec_pkg::wide_type'(ci_ff));
      diff  = sat_inner(mec_pkg::wide_type'(rr_ff) - mec_pkg::wide_type'(ii_ff));
      zr_in = sat_inner(mec_pkg::wide_type'(diff) + mec_pkg::wide_type'(cr_ff));
   end

   // iteration state
   always_ff @(posedge clock) begin
      priority if (cmd.origin) begin
         cr_ff    <= cr_in;
         ci_ff    <= ci_in;
         zr_ff    <= '0;
         zi_ff    <= '0;
         s_ff     <= '0;
         count_ff <= '0;
      end else if (cmd.update) begin
         zr_ff    <= zr_in;
         zi_ff    <= zi_in;
         s_ff     <= s_in;
         count_ff <= count_ff + ITER_BITS'(1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         result_ff <= count_ff;
      end
   end

   assign status.iterate = (s_ff < mec_pkg::INNER_FOUR) && (count_ff < cfg.max_iters);
   assign result_count   = result_ff;

endmodule
